// File: hdl/rlf_pkg.sv
// Shared types, constants and the coefficient ROM for the RC low-pass FIR filter.
// No dependencies; imported by every module of the block.
package rlf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 12;
    localparam int ROM_LEN     = 114;
    localparam int TAPS_DEF    = 50;
    localparam int PROD_W      = 28;   // |coef * sample| < 2**27
    localparam int MAG_W       = 27;
    localparam int RECIP_SHIFT = 27;   // 2**shift >= largest magnitude, so q0 is q or q-1
    localparam int RECIP_W     = 16;
    localparam int TOTAL_W     = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [COEF_W-1:0]          t_coef;

    typedef struct packed {
        logic clr;     // start a new sum
        logic valid;   // one tap enters the multiply-divide pipe
    } t_mac_ctl;

    localparam t_coef COEF_ROM [ROM_LEN] = '{
        12'd3141, 12'd2925, 12'd2724, 12'd2537, 12'd2362, 12'd2200, 12'd2048, 12'd1908,
        12'd1776, 12'd1654, 12'd1540, 12'd1434, 12'd1336, 12'd1244, 12'd1158, 12'd1079,
        12'd1004, 12'd935,  12'd871,  12'd811,  12'd755,  12'd703,  12'd655,  12'd610,
        12'd568,  12'd529,  12'd492,  12'd459,  12'd427,  12'd398,  12'd370,  12'd345,
        12'd321,  12'd299,  12'd278,  12'd259,  12'd241,  12'd225,  12'd209,  12'd195,
        12'd181,  12'd169,  12'd157,  12'd146,  12'd136,  12'd127,  12'd118,  12'd110,
        12'd102,  12'd95,   12'd89,   12'd83,   12'd77,   12'd72,   12'd67,   12'd62,
        12'd58,   12'd54,   12'd50,   12'd46,   12'd43,   12'd40,   12'd37,   12'd35,
        12'd32,   12'd30,   12'd28,   12'd26,   12'd24,   12'd23,   12'd21,   12'd19,
        12'd18,   12'd17,   12'd16,   12'd15,   12'd13,   12'd13,   12'd12,   12'd11,
        12'd10,   12'd9,    12'd9,    12'd8,    12'd7,    12'd7,    12'd6,    12'd6,
        12'd5,    12'd5,    12'd5,    12'd4,    12'd4,    12'd4,    12'd3,    12'd3,
        12'd3,    12'd3,    12'd2,    12'd2,    12'd2,    12'd2,    12'd2,    12'd2,
        12'd1,    12'd1,    12'd1,    12'd1,    12'd1,    12'd1,    12'd1,    12'd1,
        12'd1,    12'd1
    };

    // coefficients past the end of the ROM are zero
    function automatic t_coef coef_at(input logic [7:0] k);
        if (k < 8'(ROM_LEN)) begin
            return COEF_ROM[k[6:0]];
        end
        return '0;
    endfunction

    // elaboration-time sum of the first taps coefficients
    function automatic int coef_total(input int taps);
        int s;
        s = 0;
        for (int k = 0; k < taps && k < ROM_LEN; k++) begin
            s += int'(COEF_ROM[k]);
        end
        return s;
    endfunction

endpackage

// File: hdl/rc_lowpass_fir_filter.sv
// Top level of the RC low-pass FIR filter: delay-line cell chain, tap unit, control.
// Depends on rlf_pkg, rlf_cell and rlf_mac.
//
// Usage:
//   Input channel i_valid/o_ready carries i_sample_in and i_is_payload; output
//   channel o_valid/i_ready carries o_sample_out. One result per transaction.
//   A payload sample is shifted into the TAPS-cell delay line; the chain then
//   rotates once around, presenting one tap per cycle to a single shared
//   multiply/divide/accumulate unit with a four-stage pipe.
//   Each payload sample goes through the walk (S_MAC), the pipe drain (S_DRAIN)
//   and the output step (S_PUT); the block takes no new sample until it is
//   back in idle.
//   A non-payload word passes straight through r_res and S_PUT to the output
//   register; the next input is taken once the block is back in idle.
//   The output register holds a result until taken; meanwhile o_ready stays
//   up in idle so a new sample can start. If the receiver stalls, a finished
//   result waits in a holding register and o_ready stays low until it moves.
//   Reset (synchronous, active low) clears the delay line and drops o_valid.
module rc_lowpass_fir_filter #(
    parameter int TAPS = rlf_pkg::TAPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rlf_pkg::t_sample i_sample_in,
    input  logic             i_is_payload,
    output logic             o_valid,
    input  logic             i_ready,
    output rlf_pkg::t_sample o_sample_out
);
    import rlf_pkg::*;

    localparam int KW = (TAPS > 1) ? $clog2(TAPS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_PUT
    } t_state;

    t_state         r_state;
    logic [KW-1:0]  r_k;
    t_sample        r_res;
    logic           r_out_valid;
    t_sample        r_out_data;

    logic           w_in_acc;
    logic           w_load;
    logic           w_shift;
    logic           w_slot_free;
    logic           w_put;
    t_sample        w_head;
    t_sample        w_cell [TAPS];
    t_mac_ctl       w_ctl;
    t_sample        w_acc;
    logic           w_busy;

    assign o_ready     = (r_state == S_IDLE);
    assign w_in_acc    = i_valid && o_ready;
    assign w_load      = w_in_acc && i_is_payload;
    // new sample enters at the head; during the walk the tail wraps to the head
    assign w_shift     = w_load || (r_state == S_MAC);
    assign w_head      = w_load ? i_sample_in : w_cell[TAPS-1];
    assign w_slot_free = !r_out_valid || i_ready;
    assign w_put       = (r_state == S_PUT) && w_slot_free;

    genvar gi;
    generate
        for (gi = 0; gi < TAPS; gi++) begin : g_cell
            rlf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_data  ((gi == 0) ? w_head : w_cell[(gi == 0) ? 0 : gi - 1]),
                .o_data  (w_cell[gi])
            );
        end
    endgenerate

    assign w_ctl.clr   = w_load;
    assign w_ctl.valid = (r_state == S_MAC);

    rlf_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_coef   (coef_at(8'(r_k))),
        .i_sample (w_cell[TAPS-1]),
        .o_acc    (w_acc),
        .o_busy   (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_put) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_is_payload) begin
                            r_k     <= KW'(TAPS - 1);
                            r_state <= S_MAC;
                        end else begin
                            r_res   <= i_sample_in;
                            r_state <= S_PUT;
                        end
                    end
                end
                S_MAC: begin
                    if (r_k == '0) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!w_busy) begin
                        r_res   <= w_acc;
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (w_slot_free) begin
                        r_out_data <= r_res;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_data;

endmodule

// File: hdl/rlf_cell.sv
// One delay-line cell: holds one sample and passes it to its neighbor on shift.
// Depends on rlf_pkg.
module rlf_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  rlf_pkg::t_sample i_data,
    output rlf_pkg::t_sample o_data
);
    import rlf_pkg::*;

    t_sample r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

// File: hdl/rlf_mac.sv
// Tap unit: coef*sample, divide by the coefficient total (truncate toward zero)
// via reciprocal multiply plus one correction, then a 16-bit wrapping sum.
// Depends on rlf_pkg.
module rlf_mac #(
    parameter int TAPS = rlf_pkg::TAPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rlf_pkg::t_mac_ctl i_ctl,
    input  rlf_pkg::t_coef    i_coef,
    input  rlf_pkg::t_sample  i_sample,
    output rlf_pkg::t_sample  o_acc,
    output logic              o_busy
);
    import rlf_pkg::*;

    localparam int TOTAL = coef_total(TAPS);
    localparam int RECIP = (2 ** RECIP_SHIFT) / TOTAL;
    localparam int QT_W  = RECIP_W + TOTAL_W;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [TOTAL_W-1:0] TOTAL_C = TOTAL_W'(TOTAL);

    logic                           r_v1, r_v2, r_v3;
    logic signed [PROD_W-1:0]       r_prod;
    logic                           r_neg2, r_neg3;
    logic [MAG_W-1:0]               r_mag;
    logic [RECIP_W-1:0]             r_q0;
    logic [RECIP_W-1:0]             r_q;
    t_sample                        r_acc;

    logic signed [SAMPLE_W+COEF_W:0] w_prod_full;
    logic signed [PROD_W-1:0]        w_mag_full;
    logic [MAG_W+RECIP_W-1:0]        w_recip_prod;
    logic [QT_W-1:0]                 w_qt;
    logic [QT_W-1:0]                 w_rem;
    logic [RECIP_W-1:0]              w_q;
    logic [SAMPLE_W-1:0]             w_term;

    assign w_prod_full  = $signed({1'b0, i_coef}) * i_sample;
    assign w_mag_full   = r_prod[PROD_W-1] ? -r_prod : r_prod;
    assign w_recip_prod = w_mag_full[MAG_W-1:0] * RECIP_C;
    // estimate is exact or one low; fix with a single compare
    assign w_qt  = r_q0 * TOTAL_C;
    assign w_rem = QT_W'(r_mag) - w_qt;
    assign w_q   = r_q0 + RECIP_W'(w_rem >= QT_W'(TOTAL_C));
    assign w_term = r_neg3 ? (SAMPLE_W'(0) - r_q[SAMPLE_W-1:0]) : r_q[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod_full[PROD_W-1:0];
        r_neg2 <= r_prod[PROD_W-1];
        r_mag  <= w_mag_full[MAG_W-1:0];
        r_q0   <= w_recip_prod[RECIP_SHIFT +: RECIP_W];
        r_neg3 <= r_neg2;
        r_q    <= w_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + $signed(w_term);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_v1 | r_v2 | r_v3;

endmodule

// File: hdl/rlf_checker.sv
// Port-level checks for rc_lowpass_fir_filter, attached with a bind.
// Depends on rlf_pkg and the top level's ports.
module rlf_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input rlf_pkg::t_sample i_sample_in,
    input logic             i_is_payload,
    input logic             o_valid,
    input logic             i_ready,
    input rlf_pkg::t_sample o_sample_out
);
    import rlf_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sample_out)))
        else $error("output transaction dropped or changed while stalled");

    // payload transaction makes the block busy for the tap walk
    a_busy_after_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_is_payload) |=> !o_ready)
        else $error("input taken during tap walk");

    // pass-through word appears unchanged at the output when output is empty at accept
    a_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_is_payload && !o_valid) |->
            ##2 (o_valid && (o_sample_out == $past(i_sample_in, 2))))
        else $error("pass-through word lost or altered");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("block not idle after reset");

endmodule

bind rc_lowpass_fir_filter rlf_checker u_rlf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_sample_in  (i_sample_in),
    .i_is_payload (i_is_payload),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_sample_out (o_sample_out)
);
